### rtl/ringtone_note_token_decoder_unit_macros.svh
// ----------------------------------------------------------------------------
// Ringtone note decoder assertion macros
// Shared concurrent check forms; the using scope provides clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef RINGTONE_NOTE_TOKEN_DECODER_UNIT_MACROS_SVH
`define RINGTONE_NOTE_TOKEN_DECODER_UNIT_MACROS_SVH

// condition must hold on every clock edge out of reset
`define RTND_CHECK(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("rtnd check failed");

// consequent must hold whenever the antecedent holds
`define RTND_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rtnd implication failed");

`endif

### rtl/rtnd_pkg.sv
// ----------------------------------------------------------------------------
// Ringtone note decoder package
// Character codes, configuration and job types, and the letter reload table.
// ----------------------------------------------------------------------------
package rtnd_pkg;

	// character codes
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SHARP = 8'h23;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_Z  = 8'h7A;
	localparam logic [7:0] CH_CASE  = 8'h20;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_B     = 8'h42;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_F     = 8'h46;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_REST  = 8'h50;

	// register indexes
	localparam logic [1:0] CFG_BPM      = 2'd0;
	localparam logic [1:0] CFG_DFLT_DUR = 2'd1;
	localparam logic [1:0] CFG_DFLT_OCT = 2'd2;

	localparam logic [9:0] BPM_RESET      = 10'd180;
	localparam logic [5:0] DFLT_DUR_RESET = 6'd8;
	localparam logic [3:0] DFLT_OCT_RESET = 4'd6;

	localparam logic [13:0] ACC_MAX  = 14'd16383;
	localparam logic [17:0] TICK_NUM = 18'd60000;
	localparam logic [23:0] GAP_DIV  = 24'd10;

	// x / 10 as (x * GAP_RECIP) >> GAP_SHIFT, exact for any 18-bit x
	localparam logic [17:0] GAP_RECIP = 18'd209716;
	localparam int          GAP_SHIFT = 21;

	typedef struct packed {
		logic [9:0] bpm;
		logic [5:0] dflt_dur;
		logic [3:0] dflt_oct;
	} rtnd_cfg_t;

	// one note to carry out
	typedef struct packed {
		logic [7:0]  reload;
		logic        rest;
		logic [3:0]  oct;
		logic [13:0] dur;
		logic        dot;
		logic        eos;
	} rtnd_job_t;

	function automatic logic [7:0] reload_lookup(input logic [7:0] up, input logic sharp);
		logic [7:0] r;
		case (up)
			CH_A:    r = sharp ? 8'd124 : 8'd116;
			CH_B:    r = 8'd131;
			CH_C:    r = sharp ? 8'd32 : 8'd20;
			CH_D:    r = sharp ? 8'd58 : 8'd46;
			CH_E:    r = 8'd70;
			CH_F:    r = sharp ? 8'd89 : 8'd78;
			CH_G:    r = sharp ? 8'd107 : 8'd98;
			default: r = 8'd0;
		endcase
		return r;
	endfunction

endpackage

### rtl/rtnd_ifs.sv
// ----------------------------------------------------------------------------
// Ringtone note decoder channels
// Valid/ready interfaces for the character stream and the note stream.
// ----------------------------------------------------------------------------
interface rtnd_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_char;

	modport source(output valid, output char_code, output last_char, input ready);
	modport sink(input valid, input char_code, input last_char, output ready);
endinterface

interface rtnd_note_if;
	logic        valid;
	logic        ready;
	logic [7:0]  reload_value;
	logic [1:0]  prescaler_code;
	logic        is_rest;
	logic [3:0]  octave;
	logic [17:0] duration_ms;
	logic [14:0] gap_ms;
	logic        end_of_song;

	modport source(output valid, output reload_value, output prescaler_code,
		output is_rest, output octave, output duration_ms, output gap_ms,
		output end_of_song, input ready);
	modport sink(input valid, input reload_value, input prescaler_code,
		input is_rest, input octave, input duration_ms, input gap_ms,
		input end_of_song, output ready);
endinterface

### rtl/rtnd_front.sv
// ----------------------------------------------------------------------------
// Ringtone note decoder front end
// Parses characters into tokens and pushes one job per note to the queue.
// ----------------------------------------------------------------------------
`include "ringtone_note_token_decoder_unit_macros.svh"

module rtnd_front #(
	parameter int TOKEN_CHARS = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rtnd_pkg::rtnd_cfg_t cfg,
	rtnd_char_if.sink          chars,
	output rtnd_pkg::rtnd_job_t job,
	output logic               push,
	input  logic               full
);
	import rtnd_pkg::*;

	localparam int IDX_W = $clog2(TOKEN_CHARS + 1);
	localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(TOKEN_CHARS);

	logic [IDX_W-1:0] idx_q, idx_b, idx_n;
	logic             seen_q, seen_b, seen_n;
	logic [13:0]      acc_q, acc_b, acc_n;
	logic [7:0]       letter_q, letter_b, letter_n;
	logic             sharp_q, sharp_b, sharp_n;
	logic             dot_q, dot_b, dot_n;
	logic [3:0]       oct_q, oct_b, oct_n;
	logic             end_pend_q;

	logic [7:0]  c, up;
	logic        is_digit, accept, emit_note;
	logic [17:0] acc_ext;
	rtnd_job_t   note_job, end_job;

	assign c        = chars.char_code;
	assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
	assign chars.ready = !full && !end_pend_q;
	assign accept    = chars.valid && chars.ready;
	assign emit_note = accept && ((c == CH_COMMA) || chars.last_char);

	// token fields as seen by this character: a fresh token starts cleared, at the default octave
	always_comb begin
		if (idx_q == '0) begin
			idx_b    = '0;
			seen_b   = 1'b0;
			acc_b    = '0;
			letter_b = CH_SPACE;
			sharp_b  = 1'b0;
			dot_b    = 1'b0;
			oct_b    = cfg.dflt_oct;
		end else begin
			idx_b    = idx_q;
			seen_b   = seen_q;
			acc_b    = acc_q;
			letter_b = letter_q;
			sharp_b  = sharp_q;
			dot_b    = dot_q;
			oct_b    = oct_q;
		end
	end

	// take one character into the token
	assign acc_ext = 18'(acc_b) * 18'd10 + 18'(c[3:0]);

	always_comb begin
		idx_n    = idx_b;
		seen_n   = seen_b;
		acc_n    = acc_b;
		letter_n = letter_b;
		sharp_n  = sharp_b;
		dot_n    = dot_b;
		oct_n    = oct_b;
		if ((c != CH_COMMA) && (idx_b < IDX_LIMIT)) begin
			idx_n = idx_b + 1'b1;
			if (!seen_b) begin
				if (is_digit) begin
					acc_n = (acc_ext > 18'(ACC_MAX)) ? ACC_MAX : acc_ext[13:0];
				end else begin
					letter_n = c;
					seen_n   = 1'b1;
				end
			end else if (is_digit) begin
				oct_n = c[3:0];
			end else if (c == CH_DOT) begin
				dot_n = 1'b1;
			end else if (c == CH_SHARP) begin
				sharp_n = 1'b1;
			end
		end
	end

	// job for the finished token and for the closing rest
	always_comb begin
		up = letter_n;
		if ((letter_n >= CH_LC_A) && (letter_n <= CH_LC_Z))
			up = letter_n - CH_CASE;
		note_job.reload = reload_lookup(up, sharp_n);
		note_job.rest   = (up == CH_REST);
		note_job.oct    = oct_n;
		note_job.dur    = (acc_n == '0) ? 14'(cfg.dflt_dur) : acc_n;
		note_job.dot    = dot_n;
		note_job.eos    = 1'b0;

		end_job.reload = 8'd0;
		end_job.rest   = 1'b1;
		end_job.oct    = cfg.dflt_oct;
		end_job.dur    = 14'(cfg.dflt_dur);
		end_job.dot    = 1'b1;
		end_job.eos    = 1'b1;
	end

	assign push = emit_note || (end_pend_q && !full);
	assign job  = end_pend_q ? end_job : note_job;

	// token registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			end_pend_q <= 1'b0;
		end else begin
			if (accept)
				idx_q <= emit_note ? '0 : idx_n;
			if (accept && chars.last_char)
				end_pend_q <= 1'b1;
			else if (end_pend_q && !full)
				end_pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			seen_q   <= seen_n;
			acc_q    <= acc_n;
			letter_q <= letter_n;
			sharp_q  <= sharp_n;
			dot_q    <= dot_n;
			oct_q    <= oct_n;
		end
	end

	// closing rest must go out before the next character is taken
	`RTND_IMPLY(a_end_blocks_input, end_pend_q, !chars.ready)

endmodule

### rtl/rtnd_queue.sv
// ----------------------------------------------------------------------------
// Ringtone note decoder job queue
// Two-entry queue between the parser and the duration engine.
// ----------------------------------------------------------------------------
`include "ringtone_note_token_decoder_unit_macros.svh"

module rtnd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  rtnd_pkg::rtnd_job_t wr_job,
	output logic                full,
	input  logic                pop,
	output rtnd_pkg::rtnd_job_t rd_job,
	output logic                empty
);
	import rtnd_pkg::*;

	rtnd_job_t  slot_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full   = (count_q == 2'd2);
	assign empty  = (count_q == 2'd0);
	assign rd_job = slot_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= wr_job;
	end

	`RTND_IMPLY(a_no_overflow, push, !full)
	`RTND_IMPLY(a_no_underflow, pop, !empty)

endmodule

### rtl/rtnd_back.sv
// ----------------------------------------------------------------------------
// Ringtone note decoder back end
// Works out note timing with a serial divider and holds the output.
// ----------------------------------------------------------------------------
`include "ringtone_note_token_decoder_unit_macros.svh"

module rtnd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [9:0]          bpm,
	input  rtnd_pkg::rtnd_job_t rd_job,
	input  logic                empty,
	output logic                pop,
	rtnd_note_if.source         notes
);
	import rtnd_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_SCALE = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	localparam logic [4:0] DIV_LAST = 5'd17;

	logic [2:0]  state_q;
	rtnd_job_t   job_q;
	logic [23:0] divisor_q, rem_q;
	logic [17:0] quo_q, dur_q;
	logic [4:0]  cnt_q;
	logic [1:0]  presc_q;
	logic        out_valid_q;

	logic [23:0] prod;
	logic [24:0] rem_sh;
	logic        q_bit;
	logic [17:0] scaled;
	logic [35:0] gap_prod;
	logic [1:0]  presc_n;
	logic        load_out;

	assign prod   = 24'(bpm) * 24'(job_q.dur);
	assign rem_sh = {rem_q, quo_q[17]};
	assign q_bit  = (rem_sh >= {1'b0, divisor_q});
	assign scaled = {quo_q[16:0], 1'b0} + (job_q.dot ? quo_q : 18'd0);

	// gap is a tenth of the duration, by reciprocal multiply
	assign gap_prod = 36'(dur_q) * 36'(GAP_RECIP);

	// octaves 4..7 map to codes 3..0, others keep the last code
	assign presc_n = (job_q.oct[3:2] == 2'b01) ? ~job_q.oct[1:0] : presc_q;

	assign pop      = (state_q == ST_IDLE) && !empty;
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || notes.ready);

	// sequencer: multiply, divide tick count, scale, load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			presc_q     <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
				presc_q     <= presc_n;
			end else if (notes.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE:  if (!empty) state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_DIV;
				ST_DIV:   if (cnt_q == DIV_LAST) state_q <= ST_SCALE;
				ST_SCALE: state_q <= ST_DONE;
				ST_DONE:  if (load_out) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (!empty)
					job_q <= rd_job;
			end
			ST_MUL: begin
				divisor_q <= (prod == '0) ? 24'd1 : prod;
				quo_q     <= TICK_NUM;
				rem_q     <= '0;
				cnt_q     <= '0;
			end
			ST_DIV: begin
				rem_q <= q_bit ? 24'(rem_sh - {1'b0, divisor_q}) : rem_sh[23:0];
				quo_q <= {quo_q[16:0], q_bit};
				cnt_q <= cnt_q + 5'd1;
			end
			ST_SCALE: begin
				dur_q <= scaled;
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (load_out) begin
			notes.reload_value   <= job_q.reload;
			notes.prescaler_code <= presc_n;
			notes.is_rest        <= job_q.rest;
			notes.octave         <= job_q.oct;
			notes.duration_ms    <= dur_q;
			notes.gap_ms         <= gap_prod[GAP_SHIFT +: 15];
			notes.end_of_song    <= job_q.eos;
		end
	end

	assign notes.valid = out_valid_q;

	`RTND_IMPLY(a_divisor_nonzero, state_q == ST_DIV, divisor_q != '0)

endmodule

### rtl/ringtone_note_token_decoder_unit.sv
// ----------------------------------------------------------------------------
// Ringtone note token decoder
// Top level: configuration registers, parser, job queue and timing engine.
// ----------------------------------------------------------------------------
// The block takes one melody character per cycle while its two-entry job
// queue has room; a comma or the last character turns the current token into
// a note job, and the last character also queues a closing dotted rest, which
// holds the input off until that rest is queued. Each note then passes through
// the timing engine in order: the queue pop, a tempo multiply, one 18-step
// pass of the restoring divider for the tick count, a scaling step and the
// output load; the gap comes from a reciprocal multiply as a tenth of the
// duration. The engine takes a new note from the queue only once the last
// one has been loaded into the output, and the queue absorbs the closing
// rest after the last character.
module ringtone_note_token_decoder_unit #(
	parameter int TOKEN_CHARS = 5
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_data,
	rtnd_char_if.sink  chars,
	rtnd_note_if.source notes
);
	import rtnd_pkg::*;

	rtnd_cfg_t cfg_q;
	rtnd_job_t wr_job, rd_job;
	logic      push, pop, full, empty;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bpm      <= BPM_RESET;
			cfg_q.dflt_dur <= DFLT_DUR_RESET;
			cfg_q.dflt_oct <= DFLT_OCT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BPM:      cfg_q.bpm      <= cfg_data;
				CFG_DFLT_DUR: cfg_q.dflt_dur <= cfg_data[5:0];
				CFG_DFLT_OCT: cfg_q.dflt_oct <= cfg_data[3:0];
				default:      cfg_q          <= cfg_q;
			endcase
		end
	end

	rtnd_front #(
		.TOKEN_CHARS(TOKEN_CHARS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.chars  (chars),
		.job    (wr_job),
		.push   (push),
		.full   (full)
	);

	rtnd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.full   (full),
		.pop    (pop),
		.rd_job (rd_job),
		.empty  (empty)
	);

	rtnd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.bpm    (cfg_q.bpm),
		.rd_job (rd_job),
		.empty  (empty),
		.pop    (pop),
		.notes  (notes)
	);

endmodule
